/* sv/lvt_pkg.sv */
// Shared types, constants and CORDIC angle table for the landmark visibility test.
// Used by every module of the block; depends on nothing.
package lvt_pkg;

	localparam int CORDIC_STEPS  = 17;
	localparam int ANG_PI        = 205887;
	localparam int ANG_HALF_PI   = 102944;
	localparam int GAIN_Q30      = 652032874;
	localparam int NORM_TOP_BIT  = 40;

	localparam logic [15:0] ATAN_Q16 [CORDIC_STEPS] = '{
		16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024,
		16'd512, 16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2, 16'd1
	};

	typedef enum logic [2:0] {
		REG_POSE_X       = 3'd0,
		REG_POSE_Y       = 3'd1,
		REG_POSE_HEADING = 3'd2,
		REG_MAX_RANGE    = 3'd3,
		REG_MAX_ARC      = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0]        id;
		logic signed [31:0] mx;
		logic signed [31:0] my;
	} item_t;

	typedef struct packed {
		logic [15:0]        id;
		logic signed [31:0] fx;
		logic signed [31:0] fy;
		logic               range_ok;
	} frame_t;

endpackage

/* sv/lvt_sincos.sv */
// Rotation-mode CORDIC pipeline: one step per stage, yields cos/sin of the heading (Q30).
// Carries the landmark item alongside. Depends on lvt_pkg.
module lvt_sincos (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  lvt_pkg::item_t     in_item,
	input  logic signed [18:0] heading,
	output logic               out_valid,
	output lvt_pkg::item_t     out_item,
	output logic signed [32:0] cos_val,
	output logic signed [32:0] sin_val
);

	localparam int N = lvt_pkg::CORDIC_STEPS;

	logic signed [32:0] x_s [0:N];
	logic signed [32:0] y_s [0:N];
	logic signed [19:0] z_s [0:N];
	logic               flip_s [0:N];
	logic               v_s [0:N];
	lvt_pkg::item_t     item_s [0:N];

	logic signed [19:0] hd;
	logic signed [19:0] z0;
	logic               flip0;

	always_comb begin
		hd = 20'(heading);
		z0 = hd;
		flip0 = 1'b0;
		if (hd > 20'(lvt_pkg::ANG_HALF_PI)) begin
			z0 = hd - 20'(lvt_pkg::ANG_PI);
			flip0 = 1'b1;
		end else if (hd < -20'(lvt_pkg::ANG_HALF_PI)) begin
			z0 = hd + 20'(lvt_pkg::ANG_PI);
			flip0 = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= 33'(lvt_pkg::GAIN_Q30);
		y_s[0]    <= '0;
		z_s[0]    <= z0;
		flip_s[0] <= flip0;
		item_s[0] <= in_item;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [19:0] at;
		assign at = $signed({4'b0000, lvt_pkg::ATAN_Q16[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (z_s[i] >= 0) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - at;
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + at;
			end
			flip_s[i+1] <= flip_s[i];
			item_s[i+1] <= item_s[i];
		end
	end

	// undo the pi reduction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		cos_val  <= flip_s[N] ? -x_s[N] : x_s[N];
		sin_val  <= flip_s[N] ? -y_s[N] : y_s[N];
		out_item <= item_s[N];
	end

endmodule

/* sv/lvt_xform.sv */
// Pose transform (rotate, round, offset, saturate) and exact squared-range test.
// Five register stages. Depends on lvt_pkg.
module lvt_xform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  lvt_pkg::item_t     in_item,
	input  logic signed [32:0] cos_val,
	input  logic signed [32:0] sin_val,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic [30:0]        max_range,
	output logic               out_valid,
	output lvt_pkg::frame_t    out_frame
);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic [15:0]        id_s1, id_s2, id_s3, id_s4;
	logic signed [64:0] p_cx_s1, p_sy_s1, p_sx_s1, p_cy_s1;
	logic signed [35:0] tx_s2, ty_s2;
	logic signed [31:0] fx_s3, fy_s3, fx_s4, fy_s4;
	logic [63:0]        sqx_s4, sqy_s4;
	logic [61:0]        lim_s4;

	logic signed [65:0] sum_x, sum_y;
	logic signed [36:0] ox, oy;
	logic signed [31:0] sat_x, sat_y;
	logic signed [63:0] sq_x, sq_y;

	always_comb begin
		sum_x = 66'(p_cx_s1) - 66'(p_sy_s1) + 66'sd536870912;
		sum_y = 66'(p_sx_s1) + 66'(p_cy_s1) + 66'sd536870912;
		ox = 37'(tx_s2) + 37'(pose_x);
		oy = 37'(ty_s2) + 37'(pose_y);
		if (ox > 37'sd2147483647) begin
			sat_x = 32'sh7FFFFFFF;
		end else if (ox < -37'sd2147483648) begin
			sat_x = 32'sh80000000;
		end else begin
			sat_x = ox[31:0];
		end
		if (oy > 37'sd2147483647) begin
			sat_y = 32'sh7FFFFFFF;
		end else if (oy < -37'sd2147483648) begin
			sat_y = 32'sh80000000;
		end else begin
			sat_y = oy[31:0];
		end
		sq_x = 64'(fx_s3) * 64'(fx_s3);
		sq_y = 64'(fy_s3) * 64'(fy_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		p_cx_s1 <= 65'(cos_val) * 65'(in_item.mx);
		p_sy_s1 <= 65'(sin_val) * 65'(in_item.my);
		p_sx_s1 <= 65'(sin_val) * 65'(in_item.mx);
		p_cy_s1 <= 65'(cos_val) * 65'(in_item.my);
		id_s1   <= in_item.id;

		tx_s2 <= sum_x[65:30];
		ty_s2 <= sum_y[65:30];
		id_s2 <= id_s1;

		fx_s3 <= sat_x;
		fy_s3 <= sat_y;
		id_s3 <= id_s2;

		sqx_s4 <= sq_x;
		sqy_s4 <= sq_y;
		lim_s4 <= 62'(max_range) * 62'(max_range);
		fx_s4  <= fx_s3;
		fy_s4  <= fy_s3;
		id_s4  <= id_s3;

		out_frame.id       <= id_s4;
		out_frame.fx       <= fx_s4;
		out_frame.fy       <= fy_s4;
		out_frame.range_ok <= ({1'b0, sqx_s4} + {1'b0, sqy_s4}) <= {3'b000, lim_s4};
	end

endmodule

/* sv/lvt_bearing.sv */
// Absolute bearing of the transformed point: normalize, vectoring CORDIC, fold to [0, pi].
// One CORDIC step per stage. Depends on lvt_pkg.
module lvt_bearing (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  lvt_pkg::frame_t in_frame,
	output logic            out_valid,
	output lvt_pkg::frame_t out_frame,
	output logic [17:0]     bearing
);

	localparam int N = lvt_pkg::CORDIC_STEPS;

	logic [31:0]        ax, ay, big;
	logic [4:0]         lead;
	logic               v_s1;
	logic [31:0]        ax_s1, ay_s1;
	logic [5:0]         k_s1;
	lvt_pkg::frame_t    f_s1;

	logic signed [44:0] x_s [0:N];
	logic signed [44:0] y_s [0:N];
	logic signed [19:0] z_s [0:N];
	logic               v_s [0:N];
	lvt_pkg::frame_t    f_s [0:N];

	logic signed [19:0] zc;

	always_comb begin
		ax = in_frame.fx[31] ? (~in_frame.fx + 32'd1) : in_frame.fx;
		ay = in_frame.fy[31] ? (~in_frame.fy + 32'd1) : in_frame.fy;
		big = (ax > ay) ? ax : ay;
		lead = '0;
		for (int b = 0; b < 32; b++) begin
			if (big[b]) begin
				lead = 5'(b);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s[0] <= 1'b0;
		end else begin
			v_s1   <= in_valid;
			v_s[0] <= v_s1;
		end
	end

	// shift both so the larger one lands at bit 40
	always_ff @(posedge clk) begin
		ax_s1 <= ax;
		ay_s1 <= ay;
		k_s1  <= 6'(lvt_pkg::NORM_TOP_BIT) - {1'b0, lead};
		f_s1  <= in_frame;
		x_s[0] <= $signed({13'b0, ax_s1} << k_s1);
		y_s[0] <= $signed({13'b0, ay_s1} << k_s1);
		z_s[0] <= '0;
		f_s[0] <= f_s1;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [19:0] at;
		assign at = $signed({4'b0000, lvt_pkg::ATAN_Q16[i]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (y_s[i] > 0) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + at;
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - at;
			end
			f_s[i+1] <= f_s[i];
		end
	end

	always_comb begin
		if (z_s[N] < 0) begin
			zc = '0;
		end else if (z_s[N] > 20'(lvt_pkg::ANG_HALF_PI)) begin
			zc = 20'(lvt_pkg::ANG_HALF_PI);
		end else begin
			zc = z_s[N];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s[N];
		end
	end

	// mirror into the rear half-plane when x is negative
	always_ff @(posedge clk) begin
		bearing   <= f_s[N].fx[31] ? 18'(20'(lvt_pkg::ANG_PI) - zc) : zc[17:0];
		out_frame <= f_s[N];
	end

endmodule

/* sv/landmark_visibility_test_top.sv */
// Landmark visibility test: pose transform, range and bearing check per landmark item.
// done rises with the registered result, after the sincos, xform and bearing pipelines.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// Reset clears all valid bits and the pose and limit registers to zero.
// Depends on lvt_pkg, lvt_sincos, lvt_xform, lvt_bearing.
module landmark_visibility_test_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] landmark_id,
	input  logic [31:0] mark_x,
	input  logic [31:0] mark_y,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        done,
	output logic [15:0] result_id,
	output logic        visible,
	output logic [31:0] frame_x,
	output logic [31:0] frame_y
);

	logic signed [31:0] pose_x_q, pose_y_q;
	logic signed [18:0] heading_q;
	logic [30:0]        max_range_q;
	logic [17:0]        max_arc_q;

	lvt_pkg::item_t     in_item;
	logic               sc_valid, xf_valid, br_valid;
	lvt_pkg::item_t     sc_item;
	logic signed [32:0] cos_val, sin_val;
	lvt_pkg::frame_t    xf_frame, br_frame;
	logic [17:0]        bearing;

	logic               done_q, visible_q;
	logic [15:0]        id_q;
	logic [31:0]        fx_q, fy_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			heading_q   <= '0;
			max_range_q <= '0;
			max_arc_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (lvt_pkg::cfg_idx_t'(cfg_index))
				lvt_pkg::REG_POSE_X:       pose_x_q    <= cfg_data;
				lvt_pkg::REG_POSE_Y:       pose_y_q    <= cfg_data;
				lvt_pkg::REG_POSE_HEADING: heading_q   <= cfg_data[18:0];
				lvt_pkg::REG_MAX_RANGE:    max_range_q <= cfg_data[30:0];
				lvt_pkg::REG_MAX_ARC:      max_arc_q   <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	assign in_item.id = landmark_id;
	assign in_item.mx = mark_x;
	assign in_item.my = mark_y;

	lvt_sincos u_sincos (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.in_item   (in_item),
		.heading   (heading_q),
		.out_valid (sc_valid),
		.out_item  (sc_item),
		.cos_val   (cos_val),
		.sin_val   (sin_val)
	);

	lvt_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sc_valid),
		.in_item   (sc_item),
		.cos_val   (cos_val),
		.sin_val   (sin_val),
		.pose_x    (pose_x_q),
		.pose_y    (pose_y_q),
		.max_range (max_range_q),
		.out_valid (xf_valid),
		.out_frame (xf_frame)
	);

	lvt_bearing u_bearing (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (xf_valid),
		.in_frame  (xf_frame),
		.out_valid (br_valid),
		.out_frame (br_frame),
		.bearing   (bearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= br_valid;
		end
	end

	always_ff @(posedge clk) begin
		visible_q <= br_frame.range_ok && (bearing <= max_arc_q);
		id_q      <= br_frame.id;
		fx_q      <= br_frame.fx;
		fy_q      <= br_frame.fy;
	end

	assign done      = done_q;
	assign result_id = id_q;
	assign visible   = visible_q;
	assign frame_x   = fx_q;
	assign frame_y   = fy_q;

endmodule

/* verif/tb.sv */
// Self-checking testbench for landmark_visibility_test_top: directed table, then random items.
// Predicts transform, range and bearing in fixed point; depends on lvt_pkg and the block RTL.
module tb;

	localparam int LATENCY   = 45;
	localparam int N_RANDOM  = 1550;
	localparam int CYCLE_MAX = 400000;

	typedef struct {
		logic [15:0] id;
		logic        vis;
		logic [31:0] fx;
		logic [31:0] fy;
	} landmark_res_t;

	typedef struct {
		logic [15:0] id;
		logic [31:0] mx;
		logic [31:0] my;
		bit          known;
		logic        vis;
		logic [31:0] fx;
		logic [31:0] fy;
	} dir_row_t;

	logic clk, arst_n;
	logic start, busy;
	logic [15:0] landmark_id;
	logic [31:0] mark_x, mark_y;
	logic cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic done, visible;
	logic [15:0] result_id;
	logic [31:0] frame_x, frame_y;

	landmark_visibility_test_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.landmark_id(landmark_id), .mark_x(mark_x), .mark_y(mark_y),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .result_id(result_id), .visible(visible),
		.frame_x(frame_x), .frame_y(frame_y)
	);

	// shadow registers of the block
	longint sh_pose_x, sh_pose_y, sh_heading, sh_range, sh_arc;

	landmark_res_t pending_q[$];
	int errors, n_sent, n_checked, cycles;
	int idle_pct;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_MAX) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic landmark_res_t predict_visibility(logic [15:0] id, logic [31:0] mxr,
			logic [31:0] myr);
		landmark_res_t r;
		longint x, y, z, xs, ys, c, s, mx, my, fx, fy, ax, ay, b;
		logic [63:0] r2, lim;
		bit flip;
		mx = longint'($signed(mxr));
		my = longint'($signed(myr));
		x = lvt_pkg::GAIN_Q30; y = 0; z = sh_heading; flip = 0;
		if (z > lvt_pkg::ANG_HALF_PI) begin z -= lvt_pkg::ANG_PI; flip = 1; end
		else if (z < -lvt_pkg::ANG_HALF_PI) begin z += lvt_pkg::ANG_PI; flip = 1; end
		for (int i = 0; i < lvt_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i; ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= longint'(lvt_pkg::ATAN_Q16[i]);
			end else begin
				x += ys; y -= xs; z += longint'(lvt_pkg::ATAN_Q16[i]);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		fx = sat32(((c * mx - s * my + (64'sd1 <<< 29)) >>> 30) + sh_pose_x);
		fy = sat32(((s * mx + c * my + (64'sd1 <<< 29)) >>> 30) + sh_pose_y);
		r2 = fx * fx + fy * fy;
		lim = sh_range * sh_range;
		ax = fx < 0 ? -fx : fx;
		ay = fy < 0 ? -fy : fy;
		z = 0;
		if (ax == 0 && ay == 0) b = 0;
		else begin
			while ((ax > ay ? ax : ay) < (64'sd1 <<< lvt_pkg::NORM_TOP_BIT)) begin
				ax = ax <<< 1; ay = ay <<< 1;
			end
			for (int i = 0; i < lvt_pkg::CORDIC_STEPS; i++) begin
				xs = ax >>> i; ys = ay >>> i;
				if (ay > 0) begin
					ax += ys; ay -= xs; z += longint'(lvt_pkg::ATAN_Q16[i]);
				end else begin
					ax -= ys; ay += xs; z -= longint'(lvt_pkg::ATAN_Q16[i]);
				end
			end
			if (z < 0) z = 0;
			if (z > lvt_pkg::ANG_HALF_PI) z = lvt_pkg::ANG_HALF_PI;
			b = fx >= 0 ? z : lvt_pkg::ANG_PI - z;
		end
		r.id = id;
		r.vis = (r2 <= lim) && (b <= sh_arc);
		r.fx = fx[31:0];
		r.fy = fy[31:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, n_checked);
	endtask

	// results are accepted at the edge that ends their strobe cycle
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", result_id, 0);
			end else begin
				landmark_res_t e;
				e = pending_q.pop_front();
				if (result_id !== e.id) report_mismatch("result_id", result_id, e.id);
				if (visible !== e.vis) report_mismatch("visible", visible, e.vis);
				if (frame_x !== e.fx) report_mismatch("frame_x", frame_x, e.fx);
				if (frame_y !== e.fy) report_mismatch("frame_y", frame_y, e.fy);
			end
			n_checked++;
		end
	end

	// valid stays high across consecutive writes; the caller drops it
	task automatic write_reg(lvt_pkg::cfg_idx_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lvt_pkg::REG_POSE_X:       sh_pose_x = longint'($signed(val));
			lvt_pkg::REG_POSE_Y:       sh_pose_y = longint'($signed(val));
			lvt_pkg::REG_POSE_HEADING: sh_heading = longint'($signed(val[18:0]));
			lvt_pkg::REG_MAX_RANGE:    sh_range = longint'(val[30:0]);
			lvt_pkg::REG_MAX_ARC:      sh_arc = longint'(val[17:0]);
			default: ;
		endcase
	endtask

	task automatic drain_pipeline();
		start <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic set_pose(logic [31:0] px, logic [31:0] py, logic [31:0] hd,
			logic [31:0] rg, logic [31:0] arc);
		drain_pipeline();
		write_reg(lvt_pkg::REG_POSE_X, px);
		write_reg(lvt_pkg::REG_POSE_Y, py);
		write_reg(lvt_pkg::REG_POSE_HEADING, hd);
		write_reg(lvt_pkg::REG_MAX_RANGE, rg);
		write_reg(lvt_pkg::REG_MAX_ARC, arc);
		cfg_valid <= 1'b0;
	endtask

	// drive one item; start stays high across back-to-back items
	task automatic send_landmark(logic [15:0] id, logic [31:0] mx, logic [31:0] my,
			int gap_pct, landmark_res_t want);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		landmark_id <= id;
		mark_x <= mx;
		mark_y <= my;
		do @(posedge clk); while (busy);
		pending_q.push_back(want);
		n_sent++;
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom();
			1: return $urandom_range(1 << 24) - (1 << 23);
			2: return {{8{1'($urandom_range(1))}}, 24'($urandom())};
			default: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
		endcase
	endfunction

	function automatic logic [31:0] rand_heading();
		return 32'($signed($urandom_range(2 * 262143)) - 262144);
	endfunction

	dir_row_t dir_tab[$];

	initial begin
		landmark_res_t w;
		cycles = 0; errors = 0; n_sent = 0; n_checked = 0;
		start = 0; landmark_id = 0; mark_x = 0; mark_y = 0;
		cfg_valid = 0; cfg_index = lvt_pkg::REG_POSE_X; cfg_data = 0;
		sh_pose_x = 0; sh_pose_y = 0; sh_heading = 0; sh_range = 0; sh_arc = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// after reset: zero pose, zero limits; only the origin is visible
		dir_tab = '{
			'{16'h0000, 32'h0, 32'h0, 1, 1'b1, 32'h0, 32'h0},
			'{16'hffff, 32'h00010000, 32'h0, 1, 1'b0, 32'h00010000, 32'h0},
			'{16'h1234, 32'h7fffffff, 32'h80000000, 0, 0, 0, 0},
			'{16'h0001, 32'h80000000, 32'h7fffffff, 0, 0, 0, 0}
		};
		foreach (dir_tab[i]) begin
			w = predict_visibility(dir_tab[i].id, dir_tab[i].mx, dir_tab[i].my);
			if (dir_tab[i].known) begin
				w.vis = dir_tab[i].vis; w.fx = dir_tab[i].fx; w.fy = dir_tab[i].fy;
			end
			send_landmark(dir_tab[i].id, dir_tab[i].mx, dir_tab[i].my, 0, w);
		end

		// saturating pose, heading beyond pi, arc beyond pi, out-of-range register index
		set_pose(32'h7fffffff, 32'h80000000, 32'h0003_2440, 32'hffffffff, 32'h3ffff);
		drain_pipeline();
		cfg_valid <= 1'b1; cfg_index <= 3'd7; cfg_data <= 32'hdeadbeef;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dir_tab = '{
			'{16'h0010, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0},
			'{16'h0011, 32'h80000000, 32'h80000000, 0, 0, 0, 0},
			'{16'h0012, 32'h0, 32'h0, 0, 0, 0, 0},
			'{16'h0013, 32'h00010000, 32'hffff0000, 0, 0, 0, 0}
		};
		foreach (dir_tab[i]) begin
			w = predict_visibility(dir_tab[i].id, dir_tab[i].mx, dir_tab[i].my);
			send_landmark(dir_tab[i].id, dir_tab[i].mx, dir_tab[i].my, 0, w);
		end
		set_pose(32'h0, 32'h0, 32'hfffc_dbc1, 32'h7fffffff, 32'd205887);
		dir_tab = '{
			'{16'h0020, 32'h7fffffff, 32'h0, 0, 0, 0, 0},
			'{16'h0021, 32'h0, 32'h80000000, 0, 0, 0, 0},
			'{16'h0022, 32'hffffffff, 32'h00000001, 0, 0, 0, 0}
		};
		foreach (dir_tab[i]) begin
			w = predict_visibility(dir_tab[i].id, dir_tab[i].mx, dir_tab[i].my);
			send_landmark(dir_tab[i].id, dir_tab[i].mx, dir_tab[i].my, 0, w);
		end

		// random phases: new pose per block of items, varied sender gaps
		for (int ph = 0; ph < 16; ph++) begin
			idle_pct = (ph % 4 == 0) ? 0 : (ph % 4 == 1) ? 84 : (ph % 4 == 2) ? 32 : 0;
			if (ph == 0)
				set_pose(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
			else if (ph == 15)
				set_pose(32'h80000000, 32'h7fffffff, 32'h0003_2440, 32'h0, 32'h0);
			else
				set_pose(rand_coord(), rand_coord(), rand_heading(),
					$urandom_range(1) ? $urandom() : $urandom_range(1 << 26),
					$urandom_range(1) ? $urandom() : $urandom_range(205887));
			for (int k = 0; k < N_RANDOM / 16; k++) begin
				logic [15:0] id;
				logic [31:0] mx, my;
				id = 16'($urandom());
				mx = rand_coord();
				my = rand_coord();
				w = predict_visibility(id, mx, my);
				send_landmark(id, mx, my, idle_pct, w);
				// hold off until the pipeline is empty once per phase
				if (k == 40) begin
					start <= 1'b0;
					do @(posedge clk); while (pending_q.size() != 0);
				end
			end
		end

		drain_pipeline();
		$display("covered %0d landmarks over 18 pose settings, %0d results checked",
			n_sent, n_checked);
		if (errors == 0 && pending_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

/* landmark_visibility_test_top.f */
sv/lvt_pkg.sv
sv/lvt_sincos.sv
sv/lvt_xform.sv
sv/lvt_bearing.sv
sv/landmark_visibility_test_top.sv
verif/tb.sv
